### design/kscan_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kscan_pkg
// Shared types, codes and constants for the key scanner with debounce,
// auto-repeat and key-code FIFO.
// ----------------------------------------------------------------------------
package kscan_pkg;

    // Default FIFO depth. One slot always stays free, so depth-1 codes fit.
    localparam int KSCAN_FIFO_DEPTH = 8;

    // Request codes carried in the func field.
    localparam logic [1:0] FUNC_TICK  = 2'd0;
    localparam logic [1:0] FUNC_POP   = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    // Scan phases.
    localparam logic [1:0] PHASE_UP        = 2'd0;
    localparam logic [1:0] PHASE_DEBOUNCE  = 2'd1;
    localparam logic [1:0] PHASE_START_DLY = 2'd2;
    localparam logic [1:0] PHASE_RPT_DLY   = 2'd3;

    // Key codes.
    localparam logic [1:0] KEY_VOLDOWN = 2'd0;
    localparam logic [1:0] KEY_VOLUP   = 2'd1;
    localparam logic [1:0] KEY_MUTE    = 2'd2;
    localparam logic [1:0] KEY_NONE    = 2'd3;

    // Configuration register indexes and reset values.
    localparam int          CFG_IDX_W         = 8;
    localparam logic [7:0]  CFG_START_DLY     = 8'd0;
    localparam logic [7:0]  CFG_RPT_INTERVAL  = 8'd1;
    localparam logic [7:0]  START_DLY_RESET   = 8'd50;
    localparam logic [7:0]  RPT_INTERVAL_RESET = 8'd10;

    // Press timer saturation value.
    localparam logic [15:0] HELD_MAX = 16'hFFFF;

    // One input beat.
    typedef struct packed {
        logic [1:0] func;
        logic       lock;
        logic       pin_voldown_n;
        logic       pin_volup_n;
        logic       pin_mute_n;
    } kscan_in_t;

    // One result beat.
    typedef struct packed {
        logic        popped_valid;
        logic [1:0]  popped_code;
        logic        key_available;
        logic [15:0] press_time;
        logic        push_dropped;
    } kscan_out_t;

    // Push request from the scan machine to the FIFO.
    typedef struct packed {
        logic       req;
        logic [1:0] code;
    } kscan_push_t;

    // FIFO status seen by the scan machine and the result stage.
    typedef struct packed {
        logic full;
        logic avail_next;
    } kscan_fifo_stat_t;

    // Fixed-priority pin decode: volume down, then volume up, then mute.
    function automatic logic [1:0] decode_key(input logic voldown_n,
                                              input logic volup_n,
                                              input logic mute_n);
        logic [1:0] key;
        begin
            if (!voldown_n) begin
                key = KEY_VOLDOWN;
            end else if (!volup_n) begin
                key = KEY_VOLUP;
            end else if (!mute_n) begin
                key = KEY_MUTE;
            end else begin
                key = KEY_NONE;
            end
            return key;
        end
    endfunction

endpackage

### design/kscan_fsm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kscan_fsm
// Scan state machine: debounce, repeat-start delay, repeat interval and the
// saturating press timer. Issues push requests toward the key-code FIFO.
// ----------------------------------------------------------------------------
module kscan_fsm
    import kscan_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             advance,
    input  kscan_in_t        item,
    input  logic [7:0]       start_dly_cfg,
    input  logic [7:0]       rpt_interval_cfg,
    input  kscan_fifo_stat_t fifo_stat,
    output kscan_push_t      push,
    output logic             dropped,
    output logic [15:0]      held_next
);

    logic [1:0]  phase_reg, phase_next;
    logic [7:0]  start_cnt_reg, start_cnt_next;
    logic [7:0]  rpt_cnt_reg, rpt_cnt_next;
    logic [15:0] held_reg;
    logic [1:0]  key;
    logic        down;
    logic        tick;
    logic [7:0]  start_dec;
    logic [7:0]  rpt_dec;
    logic        push_req;

    assign key       = decode_key(item.pin_voldown_n, item.pin_volup_n, item.pin_mute_n);
    assign down      = (key != KEY_NONE);
    assign tick      = (item.func == FUNC_TICK) && !item.lock;
    assign start_dec = start_cnt_reg - 8'd1;
    assign rpt_dec   = rpt_cnt_reg - 8'd1;

    // Next phase, counters, timer and push request for this beat.
    always_comb begin
        phase_next     = phase_reg;
        start_cnt_next = start_cnt_reg;
        rpt_cnt_next   = rpt_cnt_reg;
        held_next      = held_reg;
        push_req       = 1'b0;
        if (tick) begin
            if (down && (held_reg != HELD_MAX)) begin
                held_next = held_reg + 16'd1;
            end
            unique case (phase_reg)
                PHASE_UP: begin
                    if (down) begin
                        phase_next = PHASE_DEBOUNCE;
                    end
                    held_next = '0;
                end
                PHASE_DEBOUNCE: begin
                    if (down) begin
                        push_req       = 1'b1;
                        start_cnt_next = start_dly_cfg;
                        phase_next     = PHASE_START_DLY;
                    end else begin
                        phase_next = PHASE_UP;
                    end
                end
                PHASE_START_DLY: begin
                    if (!down) begin
                        phase_next = PHASE_DEBOUNCE;
                    end else if (start_cnt_reg != 8'd0) begin
                        // A zero count never expires.
                        start_cnt_next = start_dec;
                        if (start_dec == 8'd0) begin
                            push_req     = 1'b1;
                            rpt_cnt_next = rpt_interval_cfg;
                            phase_next   = PHASE_RPT_DLY;
                        end
                    end
                end
                default: begin
                    if (!down) begin
                        phase_next = PHASE_DEBOUNCE;
                    end else if (rpt_cnt_reg != 8'd0) begin
                        rpt_cnt_next = rpt_dec;
                        if (rpt_dec == 8'd0) begin
                            push_req     = 1'b1;
                            rpt_cnt_next = rpt_interval_cfg;
                        end
                    end
                end
            endcase
        end else if (item.func == FUNC_CLEAR) begin
            held_next = '0;
        end
    end

    // A push into a full FIFO is dropped; the phase still advances.
    assign push.req  = push_req && !fifo_stat.full;
    assign push.code = key;
    assign dropped   = push_req && fifo_stat.full;

    // State registers, updated once per processed beat.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PHASE_UP;
            start_cnt_reg <= '0;
            rpt_cnt_reg   <= '0;
            held_reg      <= '0;
        end else if (advance) begin
            phase_reg     <= phase_next;
            start_cnt_reg <= start_cnt_next;
            rpt_cnt_reg   <= rpt_cnt_next;
            held_reg      <= held_next;
        end
    end

endmodule

### design/kscan_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kscan_fifo
// Ring FIFO of key codes. One slot always stays free to tell full from
// empty. The popped code is read into a register at the processing edge.
// ----------------------------------------------------------------------------
module kscan_fifo
    import kscan_pkg::*;
#(
    parameter int FIFO_DEPTH = KSCAN_FIFO_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             advance,
    input  logic             pop,
    input  kscan_push_t      push,
    output kscan_fifo_stat_t stat,
    output logic             pop_ok,
    output logic [1:0]       pop_code_reg
);

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(FIFO_DEPTH - 1);

    logic [1:0]       code_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_reg, wr_next;
    logic [PTR_W-1:0] rd_reg, rd_next;
    logic [PTR_W-1:0] wr_inc, rd_inc;
    logic             push_en;

    // Wrapping slot increments.
    assign wr_inc = (wr_reg == LAST_SLOT) ? '0 : wr_reg + PTR_W'(1);
    assign rd_inc = (rd_reg == LAST_SLOT) ? '0 : rd_reg + PTR_W'(1);

    assign stat.full = (wr_inc == rd_reg);
    assign pop_ok    = pop && (rd_reg != wr_reg);
    assign push_en   = advance && push.req;

    // Pointer updates for this beat; a push and a pop never share a beat.
    always_comb begin
        wr_next = wr_reg;
        rd_next = rd_reg;
        if (push.req) begin
            wr_next = wr_inc;
        end
        if (pop_ok) begin
            rd_next = rd_inc;
        end
    end

    assign stat.avail_next = (rd_next != wr_next);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg <= LAST_SLOT;
            rd_reg <= LAST_SLOT;
        end else if (advance) begin
            wr_reg <= wr_next;
            rd_reg <= rd_next;
        end
    end

    // Code storage, written on a push.
    always_ff @(posedge aclk) begin
        if (push_en) begin
            code_mem[wr_inc] <= push.code;
        end
    end

    // Registered read; reads zero when no code was popped.
    always_ff @(posedge aclk) begin
        if (advance) begin
            pop_code_reg <= pop_ok ? code_mem[rd_inc] : 2'd0;
        end
    end

endmodule

### design/key_scan_debounce_autorepeat_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_scan_debounce_autorepeat_top
// Key scanner with debounce, auto-repeat and a key-code ring FIFO.
//
// Usage:
//   s_valid/s_ready/s_data carry request beats: a scan tick with the three
//   active-low pins and the lock bit, a pop of one key code, or a clear of
//   the press timer. Every request beat yields exactly one result beat on
//   m_valid/m_ready/m_data with the pop result, FIFO status, press timer
//   and the dropped-push flag.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write the repeat-start delay
//   (index 0) and the repeat interval (index 1); other indexes are ignored.
//   cfg_ready is always high. Write only while no request is in flight.
//   From input accept to result valid the path is one input register, then
//   one pass of scan logic into the result register.
//   Throughput is one beat per cycle while the receiver keeps m_ready high;
//   the scan state and FIFO pointers are updated in that single pass.
//   When the receiver stalls, the result register holds, the input register
//   fills and then s_ready drops; no beat is lost.
//   Reset clears the scan machine, timer and FIFO pointers (FIFO empty) and
//   restores the register defaults of 50 and 10 ticks.
// ----------------------------------------------------------------------------
module key_scan_debounce_autorepeat_top
    import kscan_pkg::*;
#(
    parameter int FIFO_DEPTH = KSCAN_FIFO_DEPTH
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  kscan_in_t            s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output kscan_out_t           m_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data
);

    kscan_in_t        in_reg;
    logic             in_valid_reg;
    logic             out_valid_reg;
    logic             advance;
    logic [7:0]       start_dly_reg;
    logic [7:0]       rpt_interval_reg;
    kscan_push_t      push;
    kscan_fifo_stat_t fifo_stat;
    logic             dropped;
    logic [15:0]      held_next;
    logic             pop_ok;
    logic [1:0]       pop_code_reg;
    logic             pop_valid_reg;
    logic             avail_reg;
    logic [15:0]      press_time_reg;
    logic             dropped_reg;

    // Handshake: process the held beat whenever the result slot frees.
    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign m_valid   = out_valid_reg;
    assign cfg_ready = 1'b1;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_dly_reg    <= START_DLY_RESET;
            rpt_interval_reg <= RPT_INTERVAL_RESET;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == CFG_START_DLY) begin
                start_dly_reg <= cfg_data;
            end
            if (cfg_index == CFG_RPT_INTERVAL) begin
                rpt_interval_reg <= cfg_data;
            end
        end
    end

    kscan_fsm u_fsm (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .advance          (advance),
        .item             (in_reg),
        .start_dly_cfg    (start_dly_reg),
        .rpt_interval_cfg (rpt_interval_reg),
        .fifo_stat        (fifo_stat),
        .push             (push),
        .dropped          (dropped),
        .held_next        (held_next)
    );

    kscan_fifo #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .advance      (advance),
        .pop          (in_reg.func == FUNC_POP),
        .push         (push),
        .stat         (fifo_stat),
        .pop_ok       (pop_ok),
        .pop_code_reg (pop_code_reg)
    );

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            pop_valid_reg  <= pop_ok;
            avail_reg      <= fifo_stat.avail_next;
            press_time_reg <= held_next;
            dropped_reg    <= dropped;
        end
    end

    assign m_data.popped_valid  = pop_valid_reg;
    assign m_data.popped_code   = pop_code_reg;
    assign m_data.key_available = avail_reg;
    assign m_data.press_time    = press_time_reg;
    assign m_data.push_dropped  = dropped_reg;

endmodule

### sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the key scanner with debounce, auto-repeat and
// key-code FIFO. A behavioral model tracks the scan phase, press timer and
// FIFO for every accepted request beat. Each result beat is compared field
// by field against the oldest predicted result. Directed tests cover the
// corner cases. Randomized key-press sequences then run under several delay
// settings, with random idle gaps on both channels.
// ----------------------------------------------------------------------------
module tb;
    import kscan_pkg::*;

    localparam int         CYCLE_LIMIT      = 1500000;
    localparam int         ITEMS_PER_PHASE  = 250;
    localparam logic [1:0] FUNC_UNUSED      = 2'd3;
    localparam logic [7:0] CFG_UNUSED_IDX   = 8'd2;

    // Pin patterns, ordered {voldown_n, volup_n, mute_n}.
    localparam logic [2:0] PINS_RELEASED = 3'b111;
    localparam logic [2:0] PINS_ALL_DOWN = 3'b000;
    localparam logic [2:0] PINS_VOLDOWN  = 3'b011;
    localparam logic [2:0] PINS_VOLUP    = 3'b101;
    localparam logic [2:0] PINS_MUTE     = 3'b110;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    kscan_in_t            s_data    = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    kscan_out_t           m_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [7:0]           cfg_data  = '0;

    // Behavioral copy of the scanner state and its registers.
    logic [7:0]  mdl_start_dly = START_DLY_RESET;
    logic [7:0]  mdl_rpt_ivl   = RPT_INTERVAL_RESET;
    logic [1:0]  mdl_phase     = PHASE_UP;
    logic [7:0]  mdl_start_cnt = '0;
    logic [7:0]  mdl_rpt_cnt   = '0;
    logic [15:0] mdl_held      = '0;
    logic [1:0]  mdl_codes [KSCAN_FIFO_DEPTH];
    int          mdl_wr        = KSCAN_FIFO_DEPTH - 1;
    int          mdl_rd        = KSCAN_FIFO_DEPTH - 1;

    kscan_out_t  pending_results [$];
    int          fail_count  = 0;
    int          beats_sent  = 0;
    int          cycle_count = 0;
    int          rx_wait     = 0;
    bit          tx_idle_en  = 1'b1;
    bit          rx_idle_en  = 1'b1;

    key_scan_debounce_autorepeat_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 aclk = ~aclk;

    // Idle gap length: mostly none or short, now and then long.
    function automatic int next_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end else if (r < 98) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic int slot_after(int s);
        return (s + 1 >= KSCAN_FIFO_DEPTH) ? 0 : s + 1;
    endfunction

    // Stores a key code; returns 0 when the FIFO is full and the code is lost.
    function automatic bit store_code(logic [1:0] code);
        int n;
        n = slot_after(mdl_wr);
        if (n == mdl_rd) begin
            return 1'b0;
        end
        mdl_wr = n;
        mdl_codes[n] = code;
        return 1'b1;
    endfunction

    // Advances the model by one request beat and returns the result it gives.
    function automatic kscan_out_t predict_key_result(kscan_in_t beat);
        kscan_out_t res;
        logic [1:0] key;
        logic       down;
        res = '0;
        case (beat.func)
            FUNC_TICK: begin
                if (!beat.lock) begin
                    // Fixed priority: volume down, volume up, mute.
                    if (!beat.pin_voldown_n) begin
                        key = KEY_VOLDOWN;
                    end else if (!beat.pin_volup_n) begin
                        key = KEY_VOLUP;
                    end else if (!beat.pin_mute_n) begin
                        key = KEY_MUTE;
                    end else begin
                        key = KEY_NONE;
                    end
                    down = (key != KEY_NONE);
                    if (down && mdl_held != HELD_MAX) begin
                        mdl_held = mdl_held + 16'd1;
                    end
                    case (mdl_phase)
                        PHASE_UP: begin
                            if (down) begin
                                mdl_phase = PHASE_DEBOUNCE;
                            end
                            mdl_held = '0;
                        end
                        PHASE_DEBOUNCE: begin
                            if (down) begin
                                res.push_dropped = !store_code(key);
                                mdl_start_cnt = mdl_start_dly;
                                mdl_phase = PHASE_START_DLY;
                            end else begin
                                mdl_phase = PHASE_UP;
                            end
                        end
                        PHASE_START_DLY: begin
                            if (!down) begin
                                mdl_phase = PHASE_DEBOUNCE;
                            end else if (mdl_start_cnt != 8'd0) begin
                                mdl_start_cnt = mdl_start_cnt - 8'd1;
                                if (mdl_start_cnt == 8'd0) begin
                                    res.push_dropped = !store_code(key);
                                    mdl_rpt_cnt = mdl_rpt_ivl;
                                    mdl_phase = PHASE_RPT_DLY;
                                end
                            end
                        end
                        default: begin
                            if (!down) begin
                                mdl_phase = PHASE_DEBOUNCE;
                            end else if (mdl_rpt_cnt != 8'd0) begin
                                mdl_rpt_cnt = mdl_rpt_cnt - 8'd1;
                                if (mdl_rpt_cnt == 8'd0) begin
                                    res.push_dropped = !store_code(key);
                                    mdl_rpt_cnt = mdl_rpt_ivl;
                                end
                            end
                        end
                    endcase
                end
            end
            FUNC_POP: begin
                if (mdl_rd != mdl_wr) begin
                    mdl_rd = slot_after(mdl_rd);
                    res.popped_valid = 1'b1;
                    res.popped_code = mdl_codes[mdl_rd];
                end
            end
            FUNC_CLEAR: begin
                mdl_held = '0;
            end
            default: begin
            end
        endcase
        res.key_available = (mdl_rd != mdl_wr);
        res.press_time = mdl_held;
        return res;
    endfunction

    function automatic kscan_in_t make_beat(logic [1:0] fn, logic lk, logic [2:0] pins);
        kscan_in_t beat;
        beat.func = fn;
        beat.lock = lk;
        {beat.pin_voldown_n, beat.pin_volup_n, beat.pin_mute_n} = pins;
        return beat;
    endfunction

    task automatic compare_field(input string name, input logic [15:0] want,
                                 input logic [15:0] got);
        if (got !== want) begin
            $error("%s expected %0d actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    // Checks result beats, predicts accepted request beats and tracks
    // register writes. Results are checked before new predictions are queued.
    always @(posedge aclk) begin : scoreboard
        kscan_out_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    $error("result beat with no predicted result pending");
                    fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    compare_field("popped_valid", 16'(want.popped_valid),
                                  16'(m_data.popped_valid));
                    compare_field("popped_code", 16'(want.popped_code),
                                  16'(m_data.popped_code));
                    compare_field("key_available", 16'(want.key_available),
                                  16'(m_data.key_available));
                    compare_field("press_time", want.press_time, m_data.press_time);
                    compare_field("push_dropped", 16'(want.push_dropped),
                                  16'(m_data.push_dropped));
                end
            end
            if (s_valid && s_ready) begin
                pending_results.push_back(predict_key_result(s_data));
            end
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_START_DLY) begin
                    mdl_start_dly = cfg_data;
                end else if (cfg_index == CFG_RPT_INTERVAL) begin
                    mdl_rpt_ivl = cfg_data;
                end
            end
        end
    end

    // Result-side back-pressure.
    always @(posedge aclk) begin : result_stall
        int g;
        if (rx_wait > 0) begin
            rx_wait = rx_wait - 1;
            m_ready <= 1'b0;
        end else begin
            g = rx_idle_en ? next_gap() : 0;
            if (g == 0) begin
                m_ready <= 1'b1;
            end else begin
                rx_wait = g - 1;
                m_ready <= 1'b0;
            end
        end
    end

    // Run watchdog.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Sends one request beat. Valid stays high into the next beat when no gap
    // is drawn, so back-to-back beats keep the channel busy.
    task automatic send_beat(input kscan_in_t beat);
        int gap;
        gap = tx_idle_en ? next_gap() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= beat;
        do @(posedge aclk); while (!s_ready);
        if (beat.func != FUNC_UNUSED && !(beat.func == FUNC_TICK && beat.lock)) begin
            beats_sent++;
        end
    endtask

    task automatic send_tick(input logic [2:0] pins);
        send_beat(make_beat(FUNC_TICK, 1'b0, pins));
    endtask

    // Holds the request side idle until every predicted result has arrived.
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic write_config(input logic [7:0] start_dly, input logic [7:0] rpt_ivl);
        drain_results();
        repeat (4) @(posedge aclk);
        write_reg(CFG_START_DLY, start_dly);
        write_reg(CFG_RPT_INTERVAL, rpt_ivl);
    endtask

    // Pops on an empty FIFO, the unused request code, clear and locked ticks.
    task automatic test_idle_requests();
        send_beat(make_beat(FUNC_POP, 1'b1, PINS_ALL_DOWN));
        send_beat(make_beat(FUNC_UNUSED, 1'b0, PINS_ALL_DOWN));
        send_beat(make_beat(FUNC_CLEAR, 1'b1, PINS_RELEASED));
        send_beat(make_beat(FUNC_TICK, 1'b1, PINS_ALL_DOWN));
        send_tick(PINS_RELEASED);
    endtask

    // Pin priority, confirmed press, start delay, repeat and release paths.
    task automatic test_press_and_repeat();
        write_config(8'd1, 8'd1);
        write_reg(CFG_UNUSED_IDX, 8'hFF);
        send_tick(PINS_ALL_DOWN);
        send_tick(PINS_ALL_DOWN);
        send_tick(PINS_VOLUP);
        send_beat(make_beat(FUNC_TICK, 1'b1, PINS_MUTE));
        send_tick(PINS_MUTE);
        // Release while repeating falls back to debounce.
        send_tick(PINS_RELEASED);
        send_tick(PINS_VOLDOWN);
        send_tick(PINS_RELEASED);
    endtask

    // A zero start delay or a zero repeat interval never expires.
    task automatic test_zero_delay();
        write_config(8'd0, 8'd10);
        repeat (3) send_tick(PINS_VOLUP);
        write_config(8'd1, 8'd0);
        send_tick(PINS_RELEASED);
        repeat (3) send_tick(PINS_MUTE);
    endtask

    // Pushes into a full FIFO are dropped, then the FIFO is emptied past the end.
    task automatic test_fifo_overflow();
        write_config(8'd1, 8'd1);
        send_tick(PINS_RELEASED);
        repeat (2) send_tick(PINS_MUTE);
        repeat (KSCAN_FIFO_DEPTH) send_beat(make_beat(FUNC_POP, 1'b0, PINS_MUTE));
    endtask

    // One press-hold-release sequence with pops, clears, locks and bounce mixed in.
    task automatic random_key_press();
        logic [2:0] pins;
        int         hold;
        int         i;
        int         r;
        pins = 3'($urandom_range(0, 6));
        hold = int'(mdl_start_dly) + 2 * int'(mdl_rpt_ivl) + 4;
        if (hold > 300) begin
            hold = 300;
        end
        hold = $urandom_range(1, hold);
        for (i = 0; i < hold; i++) begin
            r = $urandom_range(0, 99);
            if (r < 25) begin
                send_beat(make_beat(FUNC_POP, 1'($urandom), 3'($urandom)));
            end else if (r < 28) begin
                send_beat(make_beat(FUNC_CLEAR, 1'($urandom), 3'($urandom)));
            end else if (r < 33) begin
                send_beat(make_beat(FUNC_TICK, 1'b1, pins));
            end else if (r < 36) begin
                send_tick(3'($urandom));
            end else begin
                send_tick(pins);
            end
        end
        repeat ($urandom_range(1, 3)) send_tick(PINS_RELEASED);
    endtask

    // Random traffic under one delay setting.
    task automatic test_random_phase(input logic [7:0] start_dly, input logic [7:0] rpt_ivl);
        int target;
        int r;
        write_config(start_dly, rpt_ivl);
        target = beats_sent + ITEMS_PER_PHASE;
        while (beats_sent < target) begin
            tx_idle_en = ($urandom_range(0, 4) != 0);
            rx_idle_en = ($urandom_range(0, 4) != 0);
            r = $urandom_range(0, 99);
            if (r < 75) begin
                random_key_press();
            end else if (r < 97) begin
                send_beat(kscan_in_t'(6'($urandom_range(0, 63))));
            end else begin
                drain_results();
            end
        end
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_idle_requests();
        test_press_and_repeat();
        test_zero_delay();
        test_fifo_overflow();
        test_random_phase(8'd1, 8'd1);
        test_random_phase(8'($urandom_range(2, 12)), 8'($urandom_range(1, 6)));
        test_random_phase(8'd255, 8'd1);
        test_random_phase(8'($urandom_range(1, 4)), 8'd255);
        drain_results();
        repeat (8) @(posedge aclk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

### key_scan_debounce_autorepeat_top.f
design/kscan_pkg.sv
design/kscan_fsm.sv
design/kscan_fifo.sv
design/key_scan_debounce_autorepeat_top.sv
sim/tb.sv
